FILE: src/assert_macros.svh
// assertion macros for the yuyv to yuv420 planar checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define YVP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define YVP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `YVP_ASSERT(lbl, clk, rst_n, !(expr))

`endif

FILE: src/yvp_pkg.sv
// shared constants, types and size helper for the yuyv to yuv420 planar converter
// no dependencies
`default_nettype none

package yvp_pkg;

  localparam int unsigned SizeW   = 12;
  localparam int unsigned AddrW   = 23;
  localparam int unsigned ColW    = 12;
  localparam int unsigned RowW    = 11;
  localparam int unsigned LumaW   = 22;
  localparam int unsigned ChromaW = 20;
  localparam int unsigned PlaneW  = 2;
  localparam int unsigned RegIdxW = 1;
  localparam int unsigned ByteW   = 8;

  localparam logic [SizeW-1:0] MAX_WIDTH    = 12'd2048;
  localparam logic [SizeW-1:0] MAX_HEIGHT   = 12'd2048;
  localparam logic [SizeW-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [SizeW-1:0] RESET_HEIGHT = 12'd480;

  localparam logic [RegIdxW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [RegIdxW-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [PlaneW-1:0] PLANE_Y = 2'd0;
  localparam logic [PlaneW-1:0] PLANE_U = 2'd1;
  localparam logic [PlaneW-1:0] PLANE_V = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [PlaneW-1:0] plane;
    logic [AddrW-1:0]  addr;
    logic [ByteW-1:0]  sample;
    logic              last;
  } yvp_result_t;

  // clamp, round down to even, floor at two
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] val,
                                                input logic [SizeW-1:0] limit);
    logic [SizeW-1:0] s;
    s = (val > limit) ? limit : val;
    s[0] = 1'b0;
    if (s < 12'd2) begin
      s = 12'd2;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/yvp_raster.sv
// raster position counters and planar address generation
// depends on yvp_pkg
`default_nettype none

module yvp_raster (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       restart_i,
  input  wire logic                       step_i,
  input  wire logic [yvp_pkg::ByteW-1:0]  sample_i,
  input  wire logic [yvp_pkg::SizeW-1:0]  width_i,
  input  wire logic [yvp_pkg::SizeW-1:0]  height_i,
  output yvp_pkg::yvp_result_t            result_o
);
  import yvp_pkg::*;

  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [LumaW-1:0]   y_q, y_d;
  logic [ChromaW-1:0] u_q, u_d;
  logic [ChromaW-1:0] v_q, v_d;
  logic [AddrW-1:0]   u_base_q, v_base_q;
  logic [2*SizeW-1:0] area;
  logic [SizeW:0]     two_w;
  logic               line_end, frame_end, is_y, is_u, is_v;

  assign area  = width_i * height_i;
  assign two_w = {width_i, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_base_q <= 23'd307200;
      v_base_q <= 23'd384000;
    end else begin
      u_base_q <= AddrW'(area);
      v_base_q <= AddrW'(area + (area >> 2));
    end
  end

  assign line_end  = {1'b0, col_q} >= (two_w - 13'd1);
  assign frame_end = line_end && ({1'b0, row_q} >= (height_i - 12'd1));
  assign is_y = !col_q[0];
  assign is_u = !row_q[0] && (col_q[1:0] == 2'b01);
  assign is_v = row_q[0] && (col_q[1:0] == 2'b11);

  always_comb begin
    result_o.valid  = is_y || is_u || is_v;
    result_o.sample = sample_i;
    result_o.last   = frame_end;
    if (is_y) begin
      result_o.plane = PLANE_Y;
      result_o.addr  = {1'b0, y_q};
    end else if (is_u) begin
      result_o.plane = PLANE_U;
      result_o.addr  = u_base_q + AddrW'(u_q);
    end else begin
      result_o.plane = PLANE_V;
      result_o.addr  = v_base_q + AddrW'(v_q);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    y_d   = y_q;
    u_d   = u_q;
    v_d   = v_q;
    if (restart_i || (step_i && frame_end)) begin
      col_d = '0;
      row_d = '0;
      y_d   = '0;
      u_d   = '0;
      v_d   = '0;
    end else if (step_i) begin
      if (line_end) begin
        col_d = '0;
        row_d = row_q + 11'd1;
      end else begin
        col_d = col_q + 12'd1;
      end
      if (is_y) begin
        y_d = y_q + 22'd1;
      end
      if (is_u) begin
        u_d = u_q + 20'd1;
      end
      if (is_v) begin
        v_d = v_q + 20'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      y_q   <= '0;
      u_q   <= '0;
      v_q   <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      y_q   <= y_d;
      u_q   <= u_d;
      v_q   <= v_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/yuyv_to_yuv420_planar.sv
// top level: packed yuyv 4:2:2 byte stream to planar 4:2:0 buffer writes
// depends on yvp_pkg and yvp_raster
//
// input channel: one yuyv byte per request, raster order, 2*width bytes a line.
// output channel: at most one buffer write per input byte (plane, byte offset,
// value, frame_last on the write from the frame's final byte); bytes that
// carry no sample (u on odd lines, v on even lines) give no write.
// config port: index 0 frame width, index 1 frame height; any write restarts
// the frame at offset zero. sizes are clamped to 2..2048 and rounded to even.
// path: an accepted byte goes to the input register, then its write to the
// result register, which drives the outputs.
// throughput: one byte per cycle unless the receiver stalls, set by the single
// pass from input register via counter and address adder to result register.
// reset: sizes return to 640x480 and the frame restarts; both stages empty.
// stall: while the receiver holds ready low, the result register holds and
// one more byte waits in the input register; after that in_ready_o drops.
`default_nettype none

module yuyv_to_yuv420_planar (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [yvp_pkg::RegIdxW-1:0]  cfg_index_i,
  input  wire logic [yvp_pkg::SizeW-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [yvp_pkg::ByteW-1:0]    packed_byte_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [yvp_pkg::PlaneW-1:0]   plane_select_o,
  output      logic [yvp_pkg::AddrW-1:0]    buffer_address_o,
  output      logic [yvp_pkg::ByteW-1:0]    sample_value_o,
  output      logic                         frame_last_o
);
  import yvp_pkg::*;

  logic [SizeW-1:0]  width_q, height_q;
  logic              in_vld_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_vld_q;
  logic [PlaneW-1:0] plane_q;
  logic [AddrW-1:0]  addr_q;
  logic [ByteW-1:0]  sample_q;
  logic              last_q;
  logic              advance, step, in_fire;
  yvp_result_t       result;

  assign advance    = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= eff_size(cfg_wdata_i, MAX_WIDTH);
        REG_FRAME_HEIGHT: height_q <= eff_size(cfg_wdata_i, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  yvp_raster u_raster (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .step_i    (step),
    .sample_i  (in_byte_q),
    .width_i   (width_q),
    .height_i  (height_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= packed_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= result.valid;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && result.valid) begin
      plane_q  <= result.plane;
      addr_q   <= result.addr;
      sample_q <= result.sample;
      last_q   <= result.last;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign plane_select_o   = plane_q;
  assign buffer_address_o = addr_q;
  assign sample_value_o   = sample_q;
  assign frame_last_o     = last_q;

endmodule

`default_nettype wire

FILE: src/yvp_checker.sv
// port level checks for the yuyv to yuv420 planar converter, with bind
// depends on yvp_pkg, assert_macros.svh and yuyv_to_yuv420_planar
`default_nettype none

`include "assert_macros.svh"

module yvp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [yvp_pkg::PlaneW-1:0]   plane_select_o,
  input wire logic [yvp_pkg::AddrW-1:0]    buffer_address_o,
  input wire logic [yvp_pkg::ByteW-1:0]    sample_value_o,
  input wire logic                         frame_last_o
);
  import yvp_pkg::*;

  // stalled request holds
  `YVP_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(buffer_address_o)
    && $stable(sample_value_o) && $stable(plane_select_o) && $stable(frame_last_o))

  `YVP_ASSERT_NEVER(a_plane_code, clk_i, rst_ni,
    out_valid_o && plane_select_o != PLANE_Y && plane_select_o != PLANE_U
    && plane_select_o != PLANE_V)

  // the frame always ends on a v sample
  `YVP_ASSERT(a_last_is_v, clk_i, rst_ni,
    out_valid_o && frame_last_o |-> plane_select_o == PLANE_V)

  // an empty result register never back-pressures the input
  `YVP_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

endmodule

bind yuyv_to_yuv420_planar yvp_checker u_yvp_checker (.*);

`default_nettype wire

FILE: bench/yuyv_to_yuv420_planar_tb.sv
// self-checking bench for yuyv_to_yuv420_planar: byte stream in, planar buffer writes out
// predicts every write from its own copy of the frame counters and compares field by field
// depends on yvp_pkg and the yuyv_to_yuv420_planar rtl
module yuyv_to_yuv420_planar_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import yvp_pkg::*;

  typedef struct packed {
    logic [PlaneW-1:0] plane;
    logic [AddrW-1:0]  addr;
    logic [ByteW-1:0]  value;
    logic              last;
  } plane_write_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [RegIdxW-1:0]   cfg_index_i   = REG_FRAME_WIDTH;
  logic [SizeW-1:0]     cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [ByteW-1:0]     packed_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [PlaneW-1:0]    plane_select_o;
  logic [AddrW-1:0]     buffer_address_o;
  logic [ByteW-1:0]     sample_value_o;
  logic                 frame_last_o;

  yuyv_to_yuv420_planar DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .packed_byte_i    (packed_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .plane_select_o   (plane_select_o),
    .buffer_address_o (buffer_address_o),
    .sample_value_o   (sample_value_o),
    .frame_last_o     (frame_last_o)
  );

  logic [SizeW-1:0] width_reg;
  logic [SizeW-1:0] height_reg;
  int unsigned      col_pos, row_pos, y_ptr, u_ptr, v_ptr;
  plane_write_t     pending_writes[$];

  int unsigned errors        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned writes_seen   = 0;
  int unsigned frames_seen   = 0;
  int unsigned settings_used = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400us;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned clamp_size(logic [SizeW-1:0] val, logic [SizeW-1:0] limit);
    int unsigned s;
    s = 32'((val > limit) ? limit : val);
    s = s & ~32'd1;
    if (s < 2) begin
      s = 2;
    end
    return s;
  endfunction

  function void restart_frame();
    int unsigned area;
    area = clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, MAX_HEIGHT);
    col_pos = 0;
    row_pos = 0;
    y_ptr   = 0;
    u_ptr   = area;
    v_ptr   = area + area / 4;
  endfunction

  function void convert_byte(logic [ByteW-1:0] b);
    int unsigned  w, h;
    bit           line_end, frame_end, hit;
    plane_write_t wr;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    line_end  = col_pos >= 2 * w - 1;
    frame_end = line_end && (row_pos >= h - 1);
    hit = 1'b1;
    wr  = '0;
    if (col_pos[0] == 1'b0) begin
      wr.plane = PLANE_Y;
      wr.addr  = y_ptr[AddrW-1:0];
      y_ptr++;
    end else if (row_pos[0] == 1'b0 && col_pos[1:0] == 2'd1) begin
      wr.plane = PLANE_U;
      wr.addr  = u_ptr[AddrW-1:0];
      u_ptr++;
    end else if (row_pos[0] == 1'b1 && col_pos[1:0] == 2'd3) begin
      wr.plane = PLANE_V;
      wr.addr  = v_ptr[AddrW-1:0];
      v_ptr++;
    end else begin
      hit = 1'b0;
    end
    wr.value = b;
    wr.last  = frame_end;
    if (hit) begin
      pending_writes.push_back(wr);
    end
    if (frame_end) begin
      restart_frame();
    end else if (line_end) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      convert_byte(packed_byte_i);
      bytes_sent++;
    end
  end

  always @(posedge clk_i) begin : check_writes
    plane_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected buffer write: plane %0d address %0d value %0d",
               plane_select_o, buffer_address_o, sample_value_o);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        writes_seen++;
        if (want.last) begin
          frames_seen++;
        end
        if (plane_select_o !== want.plane) begin
          $error("plane_select expected %0d got %0d", want.plane, plane_select_o);
          errors++;
        end
        if (buffer_address_o !== want.addr) begin
          $error("buffer_address expected %0d got %0d", want.addr, buffer_address_o);
          errors++;
        end
        if (sample_value_o !== want.value) begin
          $error("sample_value expected %0d got %0d", want.value, sample_value_o);
          errors++;
        end
        if (frame_last_o !== want.last) begin
          $error("frame_last expected %0d got %0d", want.last, frame_last_o);
          errors++;
        end
      end
    end
  end

  // receiver: long hold-off when asked, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    packed_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [SizeW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
    restart_frame();
    settings_used++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [SizeW-1:0] w, input logic [SizeW-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  // default 640x480 frame straight out of reset
  task automatic test_reset_size();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    wait_idle();
  endtask

  // sizes below two act as 2x2: one whole frame, ends on a v write
  task automatic test_smallest_frame();
    set_frame(12'd0, 12'd1);
    for (int i = 0; i < 8; i++) begin
      send_byte(i[0] ? 8'hFF : 8'h00);
    end
    wait_idle();
  endtask

  // oversized and odd registers clamp to the largest frame
  task automatic test_largest_size();
    set_frame(12'hFFF, 12'hFFF);
    for (int i = 0; i < 8; i++) begin
      send_byte(8'h80 + i[7:0]);
    end
    wait_idle();
    set_frame(MAX_WIDTH, MAX_HEIGHT);
    for (int i = 0; i < 4; i++) begin
      send_byte(8'h7F - i[7:0]);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned sent, mode, r, n, frame_bytes;
    logic [SizeW-1:0] w, h;
    sent = 0;
    mode = 0;
    while (sent < 880) begin
      set_idling(mode);
      r = $urandom_range(99);
      if (r < 5) begin
        w = SizeW'($urandom_range(2049, 4095));
      end else if (r < 10) begin
        w = SizeW'($urandom_range(1000, 2048));
      end else begin
        w = SizeW'($urandom_range(0, 9));
      end
      if ($urandom_range(99) < 5) begin
        h = SizeW'($urandom_range(2048, 4095));
      end else begin
        h = SizeW'($urandom_range(0, 7));
      end
      if ($urandom_range(3) == 0) begin
        write_reg(REG_FRAME_WIDTH, w);
      end else if ($urandom_range(3) == 0) begin
        write_reg(REG_FRAME_HEIGHT, h);
      end else begin
        set_frame(w, h);
      end
      frame_bytes = 2 * clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, MAX_HEIGHT);
      if (width_reg >= 1000) begin
        n = $urandom_range(4, 20);
      end else begin
        n = $urandom_range(frame_bytes / 2, frame_bytes * 3);
        if (n > 120) begin
          n = $urandom_range(60, 120);
        end
      end
      for (int i = 0; i < n; i++) begin
        send_byte(ByteW'($urandom_range(255)));
        sent++;
      end
      wait_idle();
      mode++;
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    set_idling(0);
    set_frame(12'd4, 12'd4);
    hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      send_byte(ByteW'($urandom_range(255)));
    end
    wait_idle();
  endtask

  initial begin
    width_reg  = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    restart_frame();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size();
    test_smallest_frame();
    test_largest_size();
    test_random_traffic();
    test_backpressure();

    repeat (8) @(posedge clk_i);
    if (pending_writes.size() != 0) begin
      $error("%0d buffer writes never arrived", pending_writes.size());
      errors++;
    end
    $display("run: %0d bytes in, %0d buffer writes checked, %0d frame ends",
             bytes_sent, writes_seen, frames_seen);
    $display("     across %0d size register writes, with idle, stall and hold-off phases",
             settings_used);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
